// File: src/dir_pkg.sv
package dir_pkg;

  // Request kinds carried by an input transaction
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_DONE  = 2'd2,
    REQ_BLOCK = 2'd3
  } req_type_t;

  // Register word indexes
  localparam logic [3:0] REG_STATUS = 4'd0;
  localparam logic [3:0] REG_COVER  = 4'd1;
  localparam logic [3:0] REG_CMD    = 4'd2;
  localparam logic [3:0] REG_ARG0   = 4'd3;
  localparam logic [3:0] REG_ARG1   = 4'd4;
  localparam logic [3:0] REG_ADDR   = 4'd5;
  localparam logic [3:0] REG_LEN    = 4'd6;
  localparam logic [3:0] REG_CTRL   = 4'd7;
  localparam logic [3:0] REG_IMM    = 4'd8;
  localparam int unsigned NUM_REGS  = 9;
  localparam logic [3:0] REG_LAST   = 4'd8;

  // Configuration register indexes
  localparam logic CFG_DISC_SELECT = 1'b0;
  localparam logic CFG_SECOND_DISC = 1'b1;

  // Command opcodes (top byte of the command word)
  localparam logic [7:0] CMD_READ         = 8'hA8;
  localparam logic [7:0] CMD_ID           = 8'hE0;
  localparam logic [7:0] CMD_AUDIO_STREAM = 8'hE1;
  localparam logic [7:0] CMD_AUDIO_STATUS = 8'hE2;
  localparam logic [7:0] CMD_SWAP         = 8'hE3;

  // Subcommands
  localparam logic [7:0] SUB_0 = 8'd0;
  localparam logic [7:0] SUB_1 = 8'd1;
  localparam logic [7:0] SUB_2 = 8'd2;
  localparam logic [7:0] SUB_3 = 8'd3;

  // Register masks
  localparam logic [31:0] STAT_W1C_MASK   = 32'h0000_0054;
  localparam logic [31:0] STAT_WR_MASK    = 32'h0000_002B;
  localparam logic [31:0] STAT_KEEP_CLR   = 32'h0000_002A;
  localparam logic [31:0] STAT_ERR_BIT    = 32'h0000_0004;
  localparam logic [31:0] STAT_TC_BIT     = 32'h0000_0010;
  localparam logic [31:0] COVER_W1C_MASK  = 32'h0000_0004;
  localparam logic [31:0] COVER_WR_MASK   = 32'h0000_0002;
  localparam logic [31:0] DMA_MASK        = 32'h03FF_FFE0;
  localparam logic [31:0] CTRL_MASK       = 32'h0000_0007;
  localparam logic [31:0] ID_VALUE        = 32'h0102_3A00;
  localparam logic [31:0] STREAM_OFF_MASK = 32'h8000_7FFF;
  localparam logic [31:0] STREAM_LEN_MASK = 32'h0000_7FFF;
  localparam logic [31:0] STREAM_POS_MASK = 32'h1FFF_E000;

  localparam logic [31:0] AUDIO_BLOCK_BYTES = 32'd512;

  typedef struct packed {
    req_type_t   req_type;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } dir_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        read_req_valid;
    logic [31:0] read_req_offset;
    logic [25:0] read_req_length;
    logic [25:0] read_req_address;
    logic        audio_fifo_reset;
    logic        audio_filter_reset;
    logic        disc_swap_start;
  } dir_result_t;

endpackage

// File: src/dir_in_stage.sv
module dir_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [3:0]          in_reg_index,
  input  logic [31:0]         in_write_data,
  input  logic                advance,
  output logic                item_vld,
  output dir_pkg::dir_item_t  item
);

  logic               vld_r;
  logic               vld_nxt;
  dir_pkg::dir_item_t item_r;
  logic               load;

  // Hold the buffered transaction while the result side cannot move
  assign in_stall = vld_r & ~advance;
  assign load     = in_valid & ~in_stall;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.req_type   <= dir_pkg::req_type_t'(in_req_type);
      item_r.reg_index  <= in_reg_index;
      item_r.write_data <= in_write_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: src/dir_core.sv
module dir_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  dir_pkg::dir_item_t   item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_wdata,
  output dir_pkg::dir_result_t result
);

  logic [31:0] reg_r   [dir_pkg::NUM_REGS];
  logic [31:0] reg_nxt [dir_pkg::NUM_REGS];
  logic        playing_r, playing_nxt;
  logic        stopping_r, stopping_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] q_start_r, q_start_nxt;
  logic [31:0] q_len_r, q_len_nxt;
  logic        disc_select_r;
  logic        second_disc_r;

  logic [7:0]  op;
  logic [7:0]  sub;
  logic [31:0] v;
  logic [31:0] st_keep;
  logic [31:0] cv_keep;
  logic [31:0] aud_off;
  logic [31:0] aud_len;
  logic [31:0] pos_sum;
  logic [31:0] end_sum;
  logic [31:0] cmd_res;

  assign op      = reg_r[dir_pkg::REG_CMD][31:24];
  assign sub     = reg_r[dir_pkg::REG_CMD][23:16];
  assign v       = item.write_data;
  assign st_keep = reg_r[dir_pkg::REG_STATUS] & ~(v & dir_pkg::STAT_W1C_MASK);
  assign cv_keep = reg_r[dir_pkg::REG_COVER] & ~(v & dir_pkg::COVER_W1C_MASK);
  assign aud_off = (reg_r[dir_pkg::REG_ARG0] << 2) & ~dir_pkg::STREAM_OFF_MASK;
  assign aud_len = reg_r[dir_pkg::REG_ARG1] & ~dir_pkg::STREAM_LEN_MASK;
  assign pos_sum = pos_r + dir_pkg::AUDIO_BLOCK_BYTES;
  assign end_sum = start_r + len_r;

  // Immediate result of the non-read commands
  always_comb begin
    cmd_res = '0;
    case (op)
      dir_pkg::CMD_ID: begin
        if (reg_r[dir_pkg::REG_COVER][0]) cmd_res = dir_pkg::ID_VALUE;
      end
      dir_pkg::CMD_AUDIO_STATUS: begin
        case (sub)
          dir_pkg::SUB_0: cmd_res = {31'd0, playing_r};
          dir_pkg::SUB_1: cmd_res = pos_r & dir_pkg::STREAM_POS_MASK;
          dir_pkg::SUB_2: cmd_res = start_r & dir_pkg::STREAM_POS_MASK;
          dir_pkg::SUB_3: cmd_res = len_r;
          default:        cmd_res = '0;
        endcase
      end
      default: cmd_res = '0;
    endcase
  end

  // Next state and result for the transaction in the input register
  always_comb begin
    for (int i = 0; i < dir_pkg::NUM_REGS; i++) reg_nxt[i] = reg_r[i];
    playing_nxt  = playing_r;
    stopping_nxt = stopping_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    len_nxt      = len_r;
    q_start_nxt  = q_start_r;
    q_len_nxt    = q_len_r;
    result       = '0;

    case (item.req_type)
      dir_pkg::REQ_READ: begin
        if (item.reg_index <= dir_pkg::REG_LAST) result.read_data = reg_r[item.reg_index];
      end
      dir_pkg::REQ_WRITE: begin
        case (item.reg_index)
          dir_pkg::REG_STATUS: begin
            reg_nxt[dir_pkg::REG_STATUS] = (v & dir_pkg::STAT_WR_MASK)
                                         | (st_keep & ~dir_pkg::STAT_KEEP_CLR);
          end
          dir_pkg::REG_COVER: begin
            reg_nxt[dir_pkg::REG_COVER] = (v & dir_pkg::COVER_WR_MASK)
                                        | (cv_keep & ~dir_pkg::COVER_WR_MASK);
          end
          dir_pkg::REG_CMD, dir_pkg::REG_ARG0, dir_pkg::REG_ARG1, dir_pkg::REG_IMM: begin
            reg_nxt[item.reg_index] = v;
          end
          dir_pkg::REG_ADDR, dir_pkg::REG_LEN: begin
            reg_nxt[item.reg_index] = v & dir_pkg::DMA_MASK;
          end
          dir_pkg::REG_CTRL: begin
            reg_nxt[dir_pkg::REG_CTRL] = v & dir_pkg::CTRL_MASK;
            if (v[0]) begin
              if (op == dir_pkg::CMD_READ) begin
                // Sector read: issue it, or flag an error with the cover open
                if (!reg_r[dir_pkg::REG_COVER][0]) begin
                  result.read_req_valid   = 1'b1;
                  result.read_req_offset  = {disc_select_r,
                                             reg_r[dir_pkg::REG_ARG0][28:0], 2'b00};
                  result.read_req_length  = reg_r[dir_pkg::REG_LEN][25:0];
                  result.read_req_address = reg_r[dir_pkg::REG_ADDR][25:0];
                end else begin
                  reg_nxt[dir_pkg::REG_STATUS] = reg_r[dir_pkg::REG_STATUS]
                                               | dir_pkg::STAT_ERR_BIT;
                  reg_nxt[dir_pkg::REG_CTRL][0] = 1'b0;
                end
              end else begin
                // Audio stream queue and stop
                if (op == dir_pkg::CMD_AUDIO_STREAM) begin
                  if (sub == dir_pkg::SUB_0) begin
                    if (aud_off == '0 && aud_len == '0) begin
                      stopping_nxt = 1'b1;
                    end else if (!stopping_r) begin
                      q_start_nxt = aud_off;
                      q_len_nxt   = aud_len;
                      if (!playing_r) begin
                        pos_nxt                 = aud_off;
                        start_nxt               = aud_off;
                        len_nxt                 = aud_len;
                        playing_nxt             = 1'b1;
                        result.audio_fifo_reset = 1'b1;
                      end
                    end
                  end else if (sub == dir_pkg::SUB_1) begin
                    stopping_nxt              = 1'b0;
                    playing_nxt               = 1'b0;
                    result.audio_filter_reset = 1'b1;
                  end
                end
                // Disc swap: open the cover when a second image exists
                if (op == dir_pkg::CMD_SWAP && !reg_r[dir_pkg::REG_COVER][0]
                    && second_disc_r) begin
                  reg_nxt[dir_pkg::REG_COVER][0] = 1'b1;
                  result.disc_swap_start         = 1'b1;
                end
                // Complete the command
                reg_nxt[dir_pkg::REG_IMM]     = cmd_res;
                reg_nxt[dir_pkg::REG_STATUS]  = reg_r[dir_pkg::REG_STATUS]
                                              | dir_pkg::STAT_TC_BIT;
                reg_nxt[dir_pkg::REG_LEN]     = '0;
                reg_nxt[dir_pkg::REG_CTRL][0] = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      dir_pkg::REQ_DONE: begin
        reg_nxt[dir_pkg::REG_STATUS]  = reg_r[dir_pkg::REG_STATUS] | dir_pkg::STAT_TC_BIT;
        reg_nxt[dir_pkg::REG_LEN]     = '0;
        reg_nxt[dir_pkg::REG_CTRL][0] = 1'b0;
      end
      dir_pkg::REQ_BLOCK: begin
        // Advance the stream; at its end switch to the queued one
        if (playing_r) begin
          pos_nxt = pos_sum;
          if (pos_sum == end_sum) begin
            pos_nxt                   = q_start_r;
            start_nxt                 = q_start_r;
            len_nxt                   = q_len_r;
            result.audio_filter_reset = 1'b1;
            if (stopping_r) begin
              stopping_nxt = 1'b0;
              playing_nxt  = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Interrupt level after the update
    result.irq = |((reg_nxt[dir_pkg::REG_STATUS] >> 1) & reg_nxt[dir_pkg::REG_STATUS]
                   & dir_pkg::STAT_KEEP_CLR)
               | (reg_nxt[dir_pkg::REG_COVER][2] & reg_nxt[dir_pkg::REG_COVER][1]);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dir_pkg::NUM_REGS; i++) reg_r[i] <= '0;
      playing_r     <= 1'b0;
      stopping_r    <= 1'b0;
      pos_r         <= '0;
      start_r       <= '0;
      len_r         <= '0;
      q_start_r     <= '0;
      q_len_r       <= '0;
      disc_select_r <= 1'b0;
      second_disc_r <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < dir_pkg::NUM_REGS; i++) reg_r[i] <= reg_nxt[i];
        playing_r  <= playing_nxt;
        stopping_r <= stopping_nxt;
        pos_r      <= pos_nxt;
        start_r    <= start_nxt;
        len_r      <= len_nxt;
        q_start_r  <= q_start_nxt;
        q_len_r    <= q_len_nxt;
      end
      if (cfg_we && cfg_index == dir_pkg::CFG_DISC_SELECT) disc_select_r <= cfg_wdata;
      if (cfg_we && cfg_index == dir_pkg::CFG_SECOND_DISC) second_disc_r <= cfg_wdata;
    end
  end

endmodule

// File: src/disc_interface_register_emulator.sv
// Pipeline: the input register takes the transaction, then the result register takes
// its result; both hold while the result side stalls.
// Throughput: one transaction per cycle while out_stall is low; all work is done
// combinationally between the input register and the result register.
// Reset: synchronous, active low; clears the register bank, stream state,
// configuration and both valid flags.
module disc_interface_register_emulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq,
  output logic        out_read_req_valid,
  output logic [31:0] out_read_req_offset,
  output logic [25:0] out_read_req_length,
  output logic [25:0] out_read_req_address,
  output logic        out_audio_fifo_reset,
  output logic        out_audio_filter_reset,
  output logic        out_disc_swap_start,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  logic                 advance;
  logic                 fire;
  logic                 item_vld;
  dir_pkg::dir_item_t   item;
  dir_pkg::dir_result_t res;
  dir_pkg::dir_result_t res_r;
  logic                 out_vld_r;
  logic                 out_vld_nxt;

  // Result register can take a new transaction when empty or being drained
  assign advance = ~out_vld_r | ~out_stall;
  assign fire    = item_vld & advance;

  dir_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_reg_index  (in_reg_index),
    .in_write_data (in_write_data),
    .advance       (advance),
    .item_vld      (item_vld),
    .item          (item)
  );

  dir_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result    (res)
  );

  // Result register
  assign out_vld_nxt = advance ? item_vld : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_read_data          = res_r.read_data;
  assign out_irq                = res_r.irq;
  assign out_read_req_valid     = res_r.read_req_valid;
  assign out_read_req_offset    = res_r.read_req_offset;
  assign out_read_req_length    = res_r.read_req_length;
  assign out_read_req_address   = res_r.read_req_address;
  assign out_audio_fifo_reset   = res_r.audio_fifo_reset;
  assign out_audio_filter_reset = res_r.audio_filter_reset;
  assign out_disc_swap_start    = res_r.disc_swap_start;

`ifndef SYNTH
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_read_req_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_req_valid |->
      out_read_req_length[4:0] == 5'd0 && out_read_req_address[4:0] == 5'd0)
    else $error("read request length or address not 32-byte aligned");

  a_read_req_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_req_valid |->
      out_read_data == 32'd0 && !out_disc_swap_start && !out_audio_fifo_reset)
    else $error("sector read combined with another command effect");

  a_fifo_filter_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_audio_fifo_reset |-> !out_audio_filter_reset)
    else $error("stream start and filter reset in one transaction");
`endif

endmodule

// File: dv/tb_disc_interface_register_emulator.sv
module tb_disc_interface_register_emulator;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam logic [31:0] CTRL_START_BIT = 32'h0000_0001;
  localparam logic [31:0] COVER_OPEN_BIT = 32'h0000_0001;

  // DUT connections
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [3:0]  in_reg_index = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq;
  logic        out_read_req_valid;
  logic [31:0] out_read_req_offset;
  logic [25:0] out_read_req_length;
  logic [25:0] out_read_req_address;
  logic        out_audio_fifo_reset;
  logic        out_audio_filter_reset;
  logic        out_disc_swap_start;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Emulated register bank and stream state
  logic [31:0] bank [0:8];
  logic        disc_sel;
  logic        disc2_ok;
  logic        playing;
  logic        stopping;
  logic [31:0] play_pos;
  logic [31:0] play_start;
  logic [31:0] play_len;
  logic [31:0] next_start;
  logic [31:0] next_len;

  // Bus accesses waiting to be driven, responses waiting to come out
  dir_pkg::dir_item_t   access_q [$];
  dir_pkg::dir_result_t response_q [$];

  int                   n_queued = 0;
  int                   n_accepted = 0;
  int                   err_cnt = 0;
  int unsigned          cycle_cnt = 0;
  int                   in_gap = 0;
  int                   out_gap = 0;
  logic                 in_taken = 1'b0;
  logic                 calm = 1'b0;
  dir_pkg::dir_item_t   drv_item;
  dir_pkg::dir_item_t   mon_item;
  dir_pkg::dir_result_t mon_want;
  dir_pkg::dir_result_t mon_got;
  dir_pkg::dir_result_t mon_pred;

  disc_interface_register_emulator u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_reg_index           (in_reg_index),
    .in_write_data          (in_write_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_data          (out_read_data),
    .out_irq                (out_irq),
    .out_read_req_valid     (out_read_req_valid),
    .out_read_req_offset    (out_read_req_offset),
    .out_read_req_length    (out_read_req_length),
    .out_read_req_address   (out_read_req_address),
    .out_audio_fifo_reset   (out_audio_fifo_reset),
    .out_audio_filter_reset (out_audio_filter_reset),
    .out_disc_swap_start    (out_disc_swap_start),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Transfer complete: raise TC, clear length and the start bit
  function automatic void end_transfer();
    bank[dir_pkg::REG_STATUS] |= dir_pkg::STAT_TC_BIT;
    bank[dir_pkg::REG_LEN] = '0;
    bank[dir_pkg::REG_CTRL] &= ~CTRL_START_BIT;
  endfunction

  // One bus access against the emulated bank; returns the expected response
  task automatic emulate_access(input dir_pkg::dir_item_t a,
                                output dir_pkg::dir_result_t r);
    logic [31:0] v;
    logic [31:0] keep;
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] imm;
    logic [7:0]  op;
    logic [7:0]  sub;
    r = '0;
    v = a.write_data;
    case (a.req_type)
      dir_pkg::REQ_READ: begin
        if (a.reg_index <= dir_pkg::REG_LAST) r.read_data = bank[a.reg_index];
      end
      dir_pkg::REQ_WRITE: begin
        case (a.reg_index)
          dir_pkg::REG_STATUS: begin
            keep = bank[dir_pkg::REG_STATUS] & ~(v & dir_pkg::STAT_W1C_MASK);
            bank[dir_pkg::REG_STATUS] = (v & dir_pkg::STAT_WR_MASK)
                                      | (keep & ~dir_pkg::STAT_KEEP_CLR);
          end
          dir_pkg::REG_COVER: begin
            keep = bank[dir_pkg::REG_COVER] & ~(v & dir_pkg::COVER_W1C_MASK);
            bank[dir_pkg::REG_COVER] = (v & dir_pkg::COVER_WR_MASK)
                                     | (keep & ~dir_pkg::COVER_WR_MASK);
          end
          dir_pkg::REG_CMD, dir_pkg::REG_ARG0, dir_pkg::REG_ARG1, dir_pkg::REG_IMM:
            bank[a.reg_index] = v;
          dir_pkg::REG_ADDR, dir_pkg::REG_LEN: bank[a.reg_index] = v & dir_pkg::DMA_MASK;
          dir_pkg::REG_CTRL: begin
            bank[dir_pkg::REG_CTRL] = v & dir_pkg::CTRL_MASK;
            if (v & CTRL_START_BIT) begin
              op  = bank[dir_pkg::REG_CMD][31:24];
              sub = bank[dir_pkg::REG_CMD][23:16];
              imm = '0;
              if (op == dir_pkg::CMD_READ) begin
                // sector read is refused while the cover is open
                if ((bank[dir_pkg::REG_COVER] & COVER_OPEN_BIT) == '0) begin
                  r.read_req_valid   = 1'b1;
                  r.read_req_offset  = {disc_sel, bank[dir_pkg::REG_ARG0][28:0], 2'b00};
                  r.read_req_length  = bank[dir_pkg::REG_LEN][25:0];
                  r.read_req_address = bank[dir_pkg::REG_ADDR][25:0];
                end else begin
                  bank[dir_pkg::REG_STATUS] |= dir_pkg::STAT_ERR_BIT;
                  bank[dir_pkg::REG_CTRL] &= ~CTRL_START_BIT;
                end
              end else begin
                case (op)
                  dir_pkg::CMD_ID: begin
                    if (bank[dir_pkg::REG_COVER] & COVER_OPEN_BIT) imm = dir_pkg::ID_VALUE;
                  end
                  dir_pkg::CMD_AUDIO_STREAM: begin
                    if (sub == dir_pkg::SUB_0) begin
                      off = (bank[dir_pkg::REG_ARG0] << 2) & ~dir_pkg::STREAM_OFF_MASK;
                      len = bank[dir_pkg::REG_ARG1] & ~dir_pkg::STREAM_LEN_MASK;
                      if (off == '0 && len == '0) begin
                        stopping = 1'b1;
                      end else if (!stopping) begin
                        next_start = off;
                        next_len   = len;
                        if (!playing) begin
                          play_pos   = off;
                          play_start = off;
                          play_len   = len;
                          playing    = 1'b1;
                          r.audio_fifo_reset = 1'b1;
                        end
                      end
                    end else if (sub == dir_pkg::SUB_1) begin
                      stopping = 1'b0;
                      playing  = 1'b0;
                      r.audio_filter_reset = 1'b1;
                    end
                  end
                  dir_pkg::CMD_AUDIO_STATUS: begin
                    case (sub)
                      dir_pkg::SUB_0: imm = {31'd0, playing};
                      dir_pkg::SUB_1: imm = play_pos & dir_pkg::STREAM_POS_MASK;
                      dir_pkg::SUB_2: imm = play_start & dir_pkg::STREAM_POS_MASK;
                      dir_pkg::SUB_3: imm = play_len;
                      default: ;
                    endcase
                  end
                  dir_pkg::CMD_SWAP: begin
                    if ((bank[dir_pkg::REG_COVER] & COVER_OPEN_BIT) == '0 && disc2_ok) begin
                      bank[dir_pkg::REG_COVER] |= COVER_OPEN_BIT;
                      r.disc_swap_start = 1'b1;
                    end
                  end
                  default: ;
                endcase
                bank[dir_pkg::REG_IMM] = imm;
                end_transfer();
              end
            end
          end
          default: ;
        endcase
      end
      dir_pkg::REQ_DONE: end_transfer();
      default: begin
        // audio block consumed; at stream end move on to the queued stream
        if (playing) begin
          play_pos += dir_pkg::AUDIO_BLOCK_BYTES;
          if (play_pos == play_start + play_len) begin
            play_pos   = next_start;
            play_start = next_start;
            play_len   = next_len;
            if (stopping) begin
              stopping = 1'b0;
              playing  = 1'b0;
            end
            r.audio_filter_reset = 1'b1;
          end
        end
      end
    endcase
    r.irq = (|((bank[dir_pkg::REG_STATUS] >> 1) & bank[dir_pkg::REG_STATUS]
               & dir_pkg::STAT_KEEP_CLR)) ||
            (|((bank[dir_pkg::REG_COVER] >> 1) & bank[dir_pkg::REG_COVER]
               & dir_pkg::COVER_WR_MASK));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
    end
  endtask

  task automatic queue_access(input dir_pkg::req_type_t t, input logic [3:0] idx,
                              input logic [31:0] data);
    dir_pkg::dir_item_t it;
    it.req_type   = t;
    it.reg_index  = idx;
    it.write_data = data;
    access_q.push_back(it);
    n_queued++;
  endtask

  // Random bus traffic: plain accesses, block bursts and command sequences
  task automatic gen_traffic(input int n);
    int          made;
    int          pick;
    int          k;
    logic [7:0]  op;
    logic [7:0]  sub;
    logic [31:0] arg0;
    logic [31:0] arg1;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        queue_access(dir_pkg::REQ_READ, 4'($urandom_range(0, 15)), $urandom);
        made++;
      end else if (pick < 40) begin
        queue_access(dir_pkg::REQ_WRITE, 4'($urandom_range(0, 15)), $urandom);
        made++;
      end else if (pick < 47) begin
        queue_access(dir_pkg::REQ_DONE, 4'($urandom), $urandom);
        made++;
      end else if (pick < 60) begin
        k = $urandom_range(1, 20);
        repeat (k) queue_access(dir_pkg::REQ_BLOCK, 4'($urandom), $urandom);
        made += k;
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    op = dir_pkg::CMD_READ;
          2:       op = dir_pkg::CMD_ID;
          3, 4, 5: op = dir_pkg::CMD_AUDIO_STREAM;
          6, 7:    op = dir_pkg::CMD_AUDIO_STATUS;
          8:       op = dir_pkg::CMD_SWAP;
          default: op = 8'($urandom);
        endcase
        sub = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        arg0 = $urandom;
        arg1 = $urandom;
        if (op == dir_pkg::CMD_AUDIO_STREAM) begin
          // mostly short streams so that block events reach the stream end
          if ($urandom_range(0, 5) == 0) begin
            arg0 &= 32'hE000_1FFF;
            arg1 &= dir_pkg::STREAM_LEN_MASK;
          end else if ($urandom_range(0, 4) != 0) begin
            arg1 = (32'($urandom_range(1, 3)) << 15) | (arg1 & dir_pkg::STREAM_LEN_MASK);
          end
        end
        queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {op, sub, 16'($urandom)});
        queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ARG0, arg0);
        queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ARG1, arg1);
        made += 3;
        if (op == dir_pkg::CMD_READ) begin
          queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ADDR, $urandom);
          queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_LEN, $urandom);
          made += 2;
        end
        queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, ($urandom_range(0, 9) == 0) ?
                     ($urandom & ~CTRL_START_BIT) : ($urandom | CTRL_START_BIT));
        made++;
        if ($urandom_range(0, 1)) begin
          queue_access(dir_pkg::REQ_READ, dir_pkg::REG_IMM, $urandom);
          made++;
        end
        if (op == dir_pkg::CMD_READ && $urandom_range(0, 3) != 0) begin
          queue_access(dir_pkg::REQ_DONE, 4'($urandom), $urandom);
          made++;
        end
      end
    end
  endtask

  // Wait until every queued access has been answered
  task automatic wait_drained();
    while (n_accepted != n_queued || response_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == dir_pkg::CFG_DISC_SELECT) disc_sel = val;
    else disc2_ok = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: holds a transaction until accepted, idles in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled, keep payload
    end else if (in_gap > 0) begin
      in_gap   <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (access_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      in_gap   <= $urandom_range(0, 9);
      in_valid <= 1'b0;
    end else begin
      drv_item = access_q.pop_front();
      in_valid      <= 1'b1;
      in_req_type   <= drv_item.req_type;
      in_reg_index  <= drv_item.reg_index;
      in_write_data <= drv_item.write_data;
    end
  end

  // Result-side backpressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap   <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check responses, predict each accepted transaction
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        mon_got.read_data          = out_read_data;
        mon_got.irq                = out_irq;
        mon_got.read_req_valid     = out_read_req_valid;
        mon_got.read_req_offset    = out_read_req_offset;
        mon_got.read_req_length    = out_read_req_length;
        mon_got.read_req_address   = out_read_req_address;
        mon_got.audio_fifo_reset   = out_audio_fifo_reset;
        mon_got.audio_filter_reset = out_audio_filter_reset;
        mon_got.disc_swap_start    = out_disc_swap_start;
        if (response_q.size() == 0) begin
          err_cnt++;
          $error("response transaction with no access outstanding");
        end else begin
          mon_want = response_q.pop_front();
          check_field("read_data", mon_want.read_data, mon_got.read_data);
          check_field("irq", 32'(mon_want.irq), 32'(mon_got.irq));
          check_field("read_req_valid", 32'(mon_want.read_req_valid),
                      32'(mon_got.read_req_valid));
          check_field("read_req_offset", mon_want.read_req_offset,
                      mon_got.read_req_offset);
          check_field("read_req_length", 32'(mon_want.read_req_length),
                      32'(mon_got.read_req_length));
          check_field("read_req_address", 32'(mon_want.read_req_address),
                      32'(mon_got.read_req_address));
          check_field("audio_fifo_reset", 32'(mon_want.audio_fifo_reset),
                      32'(mon_got.audio_fifo_reset));
          check_field("audio_filter_reset", 32'(mon_want.audio_filter_reset),
                      32'(mon_got.audio_filter_reset));
          check_field("disc_swap_start", 32'(mon_want.disc_swap_start),
                      32'(mon_got.disc_swap_start));
        end
      end
      if (in_valid && !in_stall) begin
        mon_item.req_type   = dir_pkg::req_type_t'(in_req_type);
        mon_item.reg_index  = in_reg_index;
        mon_item.write_data = in_write_data;
        emulate_access(mon_item, mon_pred);
        response_q.push_back(mon_pred);
        n_accepted++;
      end
    end
  end

  // Sequence: reset, then phases at different disc settings
  initial begin
    for (int i = 0; i < dir_pkg::NUM_REGS; i++) bank[i] = '0;
    disc_sel   = 1'b0;
    disc2_ok   = 1'b0;
    playing    = 1'b0;
    stopping   = 1'b0;
    play_pos   = '0;
    play_start = '0;
    play_len   = '0;
    next_start = '0;
    next_len   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    write_config(dir_pkg::CFG_DISC_SELECT, 1'b1);
    write_config(dir_pkg::CFG_SECOND_DISC, 1'b0);
    @(posedge clk);

    // masks and flags, unmapped words, transfer done with nothing pending
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_STATUS, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_COVER, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_DONE, 4'hF, 32'h0000_0000);
    queue_access(dir_pkg::REQ_READ, dir_pkg::REG_STATUS, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_WRITE, 4'd9, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_READ, 4'd15, 32'h0000_0000);
    // sector read at maximum field values
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ARG0, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ADDR, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_LEN, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {dir_pkg::CMD_READ, 24'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, 32'hFFFF_FFFF);
    queue_access(dir_pkg::REQ_DONE, 4'h0, 32'hFFFF_FFFF);
    // ID query with cover closed, then an unknown command
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {dir_pkg::CMD_ID, 24'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    queue_access(dir_pkg::REQ_READ, dir_pkg::REG_IMM, 32'h0);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, 32'h5A03_0000);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    // start a stream, consume a block, stop, then a block while stopped
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD,
                 {dir_pkg::CMD_AUDIO_STREAM, dir_pkg::SUB_0, 16'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ARG0, 32'h0000_2000);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_ARG1, 32'h0000_8000);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    queue_access(dir_pkg::REQ_BLOCK, 4'h0, 32'h0);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD,
                 {dir_pkg::CMD_AUDIO_STREAM, dir_pkg::SUB_1, 16'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    queue_access(dir_pkg::REQ_BLOCK, 4'h0, 32'h0);
    // swap refused with no second disc
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {dir_pkg::CMD_SWAP, 24'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    gen_traffic(600);

    wait_drained();
    write_config(dir_pkg::CFG_DISC_SELECT, 1'b0);
    @(posedge clk);
    gen_traffic(600);

    // second disc present: open the cover, then read and ID with it open
    wait_drained();
    write_config(dir_pkg::CFG_DISC_SELECT, 1'b1);
    write_config(dir_pkg::CFG_SECOND_DISC, 1'b1);
    @(posedge clk);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {dir_pkg::CMD_SWAP, 24'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {dir_pkg::CMD_READ, 24'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CMD, {dir_pkg::CMD_ID, 24'h0});
    queue_access(dir_pkg::REQ_WRITE, dir_pkg::REG_CTRL, CTRL_START_BIT);
    queue_access(dir_pkg::REQ_READ, dir_pkg::REG_IMM, 32'h0);
    gen_traffic(400);

    // final stretch runs back to back
    wait_drained();
    write_config(dir_pkg::CFG_DISC_SELECT, 1'b0);
    @(posedge clk);
    calm = 1'b1;
    gen_traffic(400);

    wait_drained();
    repeat (5) @(negedge clk);
    if (err_cnt == 0 && response_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
